/* rtl/core/lpmr_pkg.sv */
package lpmr_pkg;

	// Store geometry
	localparam int STORE_DEPTH = 4096;
	localparam int HDR_BYTES   = 4;
	localparam int POS_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = POS_W + 1;
	localparam int CAP_MIN     = HDR_BYTES + 1;

	// Item modes
	localparam logic [2:0] MODE_SEND    = 3'd0;
	localparam logic [2:0] MODE_PAYLOAD = 3'd1;
	localparam logic [2:0] MODE_RECV    = 3'd2;
	localparam logic [2:0] MODE_READ    = 3'd3;
	localparam logic [2:0] MODE_CLEAR   = 3'd4;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_INTERNAL = 3'd4;
	localparam logic [2:0] ST_SEQUENCE = 3'd5;

	// Result length source
	localparam logic [1:0] LSEL_NONE = 2'd0;
	localparam logic [1:0] LSEL_MSG  = 2'd1;
	localparam logic [1:0] LSEL_HDR  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       latch;
		logic       hdr_wr;
		logic [1:0] hdr_idx;
		logic       send_open;
		logic       pay_wr;
		logic       peek_start;
		logic       peek_rd;
		logic       collect;
		logic       recv_commit;
		logic       byte_rd;
		logic       clear;
		logic       res_load;
		logic [2:0] res_status;
		logic [1:0] res_len_sel;
		logic       res_data;
		logic       res_last;
	} lpmr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [2:0] mode;
		logic       send_open;
		logic       recv_open;
		logic       zero_len;
		logic       send_full;
		logic       fill_zero;
		logic       fill_lt_hdr;
		logic       hdr_bad;
		logic       room_short;
		logic       hdr_zero;
		logic       send_last;
	} lpmr_sts_t;

endpackage

/* rtl/core/lpmr_datapath.sv */
module lpmr_datapath import lpmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lpmr_cmd_t         cmd,
	output lpmr_sts_t         sts,
	input  logic [2:0]        mode,
	input  logic [15:0]       msg_length,
	input  logic [7:0]        data_in,
	input  logic [15:0]       reader_room,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic [2:0]        status,
	output logic [7:0]        data_out,
	output logic [15:0]       length_out,
	output logic              last_byte,
	output logic [CNT_W-1:0]  used_bytes,
	output logic [CNT_W-1:0]  free_bytes
);

	logic [7:0]       mem [STORE_DEPTH];
	logic [7:0]       rdata_q;

	logic [2:0]       mode_q;
	logic [15:0]      msg_q;
	logic [7:0]       data_q;
	logic [15:0]      room_q;
	logic [31:0]      hdr_q;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] fill_q;
	logic [POS_W-1:0] wpos_q;
	logic [POS_W-1:0] rpos_q;
	logic [POS_W-1:0] peek_q;
	logic [CNT_W-1:0] send_left_q;
	logic [CNT_W-1:0] recv_left_q;

	logic             wr_en;
	logic [7:0]       wr_data;
	logic             rd_en;
	logic [POS_W-1:0] rd_addr;
	logic [16:0]      send_need;
	logic [16:0]      hdr_need;
	logic [CNT_W-1:0] cap_clamped;

	// Step a position, wrapping at the capacity
	function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p,
	                                              input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = {1'b0, p} + CNT_W'(1);
		if (n >= cap) begin
			next_pos = '0;
		end else begin
			next_pos = n[POS_W-1:0];
		end
	endfunction

	// Select store write and read
	always_comb begin
		wr_en   = cmd.hdr_wr || cmd.pay_wr;
		wr_data = data_q;
		if (cmd.hdr_wr) begin
			case (cmd.hdr_idx)
				2'd0: wr_data = msg_q[7:0];
				2'd1: wr_data = msg_q[15:8];
				default: wr_data = 8'd0;
			endcase
		end
		rd_en   = cmd.peek_start || cmd.peek_rd || cmd.byte_rd;
		rd_addr = cmd.peek_rd ? peek_q : rpos_q;
	end

	// Byte store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wpos_q] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Capture the request and shift in header bytes
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			msg_q  <= msg_length;
			data_q <= data_in;
			room_q <= reader_room;
		end
		if (cmd.collect) begin
			hdr_q <= {rdata_q, hdr_q[31:8]};
		end
	end

	// Saturate the capacity write
	always_comb begin
		if (cfg_data < CNT_W'(CAP_MIN)) begin
			cap_clamped = CNT_W'(CAP_MIN);
		end else if (cfg_data > CNT_W'(STORE_DEPTH)) begin
			cap_clamped = CNT_W'(STORE_DEPTH);
		end else begin
			cap_clamped = cfg_data;
		end
	end

	// Ring pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CNT_W'(STORE_DEPTH);
			fill_q      <= '0;
			wpos_q      <= '0;
			rpos_q      <= '0;
			peek_q      <= '0;
			send_left_q <= '0;
			recv_left_q <= '0;
		end else if (cfg_we || cmd.clear) begin
			if (cfg_we) begin
				cap_q <= cap_clamped;
			end
			fill_q      <= '0;
			wpos_q      <= '0;
			rpos_q      <= '0;
			send_left_q <= '0;
			recv_left_q <= '0;
		end else begin
			if (wr_en) begin
				wpos_q <= next_pos(wpos_q, cap_q);
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.pay_wr) begin
				send_left_q <= send_left_q - CNT_W'(1);
			end
			if (cmd.send_open) begin
				send_left_q <= msg_q[CNT_W-1:0];
			end
			if (cmd.peek_start) begin
				peek_q <= next_pos(rpos_q, cap_q);
			end
			if (cmd.peek_rd) begin
				peek_q <= next_pos(peek_q, cap_q);
			end
			if (cmd.recv_commit) begin
				rpos_q      <= peek_q;
				fill_q      <= fill_q - CNT_W'(HDR_BYTES);
				recv_left_q <= hdr_q[CNT_W-1:0];
			end
			if (cmd.byte_rd) begin
				rpos_q      <= next_pos(rpos_q, cap_q);
				fill_q      <= fill_q - CNT_W'(1);
				recv_left_q <= recv_left_q - CNT_W'(1);
			end
		end
	end

	// Checks for the controller
	always_comb begin
		send_need       = {1'b0, msg_q} + 17'(HDR_BYTES);
		hdr_need        = {1'b0, hdr_q[15:0]} + 17'(HDR_BYTES);
		sts.mode        = mode_q;
		sts.send_open   = send_left_q != '0;
		sts.recv_open   = recv_left_q != '0;
		sts.zero_len    = msg_q == '0;
		sts.send_full   = (send_need > 17'(cap_q)) || (17'(cap_q - fill_q) < send_need);
		sts.fill_zero   = fill_q == '0;
		sts.fill_lt_hdr = fill_q < CNT_W'(HDR_BYTES);
		sts.hdr_bad     = (hdr_q[31:16] != '0) || (hdr_need > 17'(fill_q));
		sts.room_short  = room_q < hdr_q[15:0];
		sts.hdr_zero    = hdr_q == '0;
		sts.send_last   = send_left_q == CNT_W'(1);
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status    <= cmd.res_status;
			data_out  <= cmd.res_data ? rdata_q : 8'd0;
			last_byte <= cmd.res_last;
			case (cmd.res_len_sel)
				LSEL_MSG: length_out <= msg_q;
				LSEL_HDR: length_out <= hdr_q[15:0];
				default:  length_out <= 16'd0;
			endcase
		end
	end

	// Counts come straight from the ring counters and hold steady while done is high
	assign used_bytes = fill_q;
	assign free_bytes = cap_q - fill_q;

`ifndef SYNTHESIS
	a_fill_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q) else $error("fill count beyond capacity");
	a_wpos_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wpos_q} < cap_q) else $error("write position beyond capacity");
	a_rpos_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rpos_q} < cap_q) else $error("read position beyond capacity");
	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.send_open && sts.recv_open)) else $error("send and receive open together");
`endif

endmodule

/* rtl/core/lpmr_ctrl.sv */
module lpmr_ctrl import lpmr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  lpmr_sts_t sts,
	output lpmr_cmd_t cmd,
	output logic      busy,
	output logic      cfg_ready,
	output logic      done
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHECK   = 3'd1;
	localparam logic [2:0] S_HDR     = 3'd2;
	localparam logic [2:0] S_PEEK    = 3'd3;
	localparam logic [2:0] S_COLLECT = 3'd4;
	localparam logic [2:0] S_EVAL    = 3'd5;
	localparam logic [2:0] S_RD_WAIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] cnt_q;
	logic [1:0] cnt_d;
	logic       done_q;

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign done      = done_q;

	// Sequence each request
	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.hdr_idx = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.res_status = ST_OK;
				case (sts.mode)
					MODE_SEND: begin
						if (sts.send_open || sts.recv_open) begin
							cmd.res_status = ST_SEQUENCE;
							cmd.res_load   = 1'b1;
						end else if (sts.zero_len) begin
							cmd.res_status = ST_INVALID;
							cmd.res_load   = 1'b1;
						end else if (sts.send_full) begin
							cmd.res_status = ST_FULL;
							cmd.res_load   = 1'b1;
						end else begin
							cmd.hdr_wr  = 1'b1;
							cmd.hdr_idx = 2'd0;
							cnt_d       = 2'd1;
							state_d     = S_HDR;
						end
					end
					MODE_PAYLOAD: begin
						cmd.res_load = 1'b1;
						if (!sts.send_open) begin
							cmd.res_status = ST_SEQUENCE;
						end else begin
							cmd.pay_wr   = 1'b1;
							cmd.res_last = sts.send_last;
						end
					end
					MODE_RECV: begin
						if (sts.send_open || sts.recv_open) begin
							cmd.res_status = ST_SEQUENCE;
							cmd.res_load   = 1'b1;
						end else if (sts.fill_zero) begin
							cmd.res_status = ST_EMPTY;
							cmd.res_load   = 1'b1;
						end else if (sts.fill_lt_hdr) begin
							cmd.res_status = ST_INTERNAL;
							cmd.res_load   = 1'b1;
						end else begin
							cmd.peek_start = 1'b1;
							cnt_d          = 2'd1;
							state_d        = S_PEEK;
						end
					end
					MODE_READ: begin
						if (!sts.recv_open) begin
							cmd.res_status = ST_SEQUENCE;
							cmd.res_load   = 1'b1;
						end else begin
							cmd.byte_rd = 1'b1;
							state_d     = S_RD_WAIT;
						end
					end
					MODE_CLEAR: begin
						cmd.clear    = 1'b1;
						cmd.res_load = 1'b1;
					end
					default: begin
						cmd.res_status = ST_INVALID;
						cmd.res_load   = 1'b1;
					end
				endcase
				if (cmd.res_load) begin
					state_d = S_IDLE;
				end
			end
			S_HDR: begin
				cmd.hdr_wr = 1'b1;
				if (cnt_q == 2'd3) begin
					cmd.send_open   = 1'b1;
					cmd.res_load    = 1'b1;
					cmd.res_status  = ST_OK;
					cmd.res_len_sel = LSEL_MSG;
					state_d         = S_IDLE;
				end else begin
					cnt_d = cnt_q + 2'd1;
				end
			end
			S_PEEK: begin
				cmd.peek_rd = 1'b1;
				cmd.collect = 1'b1;
				if (cnt_q == 2'd3) begin
					state_d = S_COLLECT;
				end else begin
					cnt_d = cnt_q + 2'd1;
				end
			end
			S_COLLECT: begin
				cmd.collect = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				cmd.res_load = 1'b1;
				state_d      = S_IDLE;
				if (sts.hdr_bad) begin
					cmd.res_status = ST_INTERNAL;
				end else if (sts.room_short) begin
					cmd.res_status = ST_FULL;
				end else begin
					cmd.recv_commit = 1'b1;
					cmd.res_status  = ST_OK;
					cmd.res_len_sel = LSEL_HDR;
					cmd.res_last    = sts.hdr_zero;
				end
			end
			S_RD_WAIT: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_data   = 1'b1;
				cmd.res_last   = !sts.recv_open;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state and raise the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= cmd.res_load;
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE) else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done_q)) else $error("accepted request not started");
	a_load_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> state_d == S_IDLE) else $error("result loaded mid request");
`endif

endmodule

/* rtl/core/length_prefixed_message_ring.sv */
// Sequence: done is registered from the last state's result load. payload_byte, clear
// and rejected requests end in the check state, read_byte in a read wait, begin_send
// after four header writes (check, header) and begin_receive after four header reads
// (check, peek, collect, eval). Requests are taken only in idle; the byte store takes
// one header byte per cycle. The receiver cannot stall; done is high for one cycle.
// Reset: asynchronous, active low; capacity 4096, ring empty, no clearing pass.
module length_prefixed_message_ring import lpmr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        mode,
	input  logic [15:0]       msg_length,
	input  logic [7:0]        data_in,
	input  logic [15:0]       reader_room,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              done,
	output logic [2:0]        status,
	output logic [7:0]        data_out,
	output logic [15:0]       length_out,
	output logic              last_byte,
	output logic [CNT_W-1:0]  used_bytes,
	output logic [CNT_W-1:0]  free_bytes
);

	lpmr_cmd_t cmd;
	lpmr_sts_t sts;

	lpmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done)
	);

	lpmr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.msg_length  (msg_length),
		.data_in     (data_in),
		.reader_room (reader_room),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.status      (status),
		.data_out    (data_out),
		.length_out  (length_out),
		.last_byte   (last_byte),
		.used_bytes  (used_bytes),
		.free_bytes  (free_bytes)
	);

endmodule

/* tb/sv/tb_length_prefixed_message_ring.sv */
`timescale 1ns / 100ps

module tb_length_prefixed_message_ring import lpmr_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int CFG_SETTLE     = 8;

	// Mode codes the block does not define
	localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] MODE_UNUSED_MID   = 3'd6;
	localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

	typedef struct {
		logic [2:0]  mode;
		logic [15:0] msg_length;
		logic [7:0]  data_in;
		logic [15:0] reader_room;
	} ring_request_t;

	typedef struct {
		logic [2:0]       status;
		logic [7:0]       data_out;
		logic [15:0]      length_out;
		logic             last_byte;
		logic [CNT_W-1:0] used_bytes;
		logic [CNT_W-1:0] free_bytes;
	} ring_result_t;

	// Ring predictor plus the queue of results still owed by the block
	class msg_ring_scoreboard;
		logic [7:0]   byte_store [STORE_DEPTH];
		int unsigned  rd_pos;
		int unsigned  wr_pos;
		int unsigned  fill;
		int unsigned  send_left;
		int unsigned  recv_left;
		int unsigned  capacity;
		int unsigned  mismatches;
		ring_result_t pending_results[$];

		function new();
			capacity   = STORE_DEPTH;
			mismatches = 0;
			wipe();
		endfunction

		function void wipe();
			rd_pos    = 0;
			wr_pos    = 0;
			fill      = 0;
			send_left = 0;
			recv_left = 0;
		endfunction

		// Saturate the written capacity and empty the ring
		function void set_capacity(logic [CNT_W-1:0] value);
			if (value < CAP_MIN) begin
				capacity = CAP_MIN;
			end else if (value > STORE_DEPTH) begin
				capacity = STORE_DEPTH;
			end else begin
				capacity = value;
			end
			wipe();
		endfunction

		function int unsigned step_pos(int unsigned p);
			return (p + 1 >= capacity) ? 0 : p + 1;
		endfunction

		function void put_byte(logic [7:0] b);
			byte_store[wr_pos] = b;
			wr_pos = step_pos(wr_pos);
			fill++;
		endfunction

		function logic [7:0] take_byte();
			logic [7:0] b;
			b = byte_store[rd_pos];
			rd_pos = step_pos(rd_pos);
			if (fill > 0) begin
				fill--;
			end
			return b;
		endfunction

		// Advance the ring by one accepted request and queue its result
		function void note_request(ring_request_t rq);
			ring_result_t res;
			int unsigned  need;
			int unsigned  hdr_len;
			int unsigned  p;
			bit           in_progress;
			res.status     = ST_OK;
			res.data_out   = 8'h00;
			res.length_out = 16'h0000;
			res.last_byte  = 1'b0;
			in_progress = (send_left != 0) || (recv_left != 0);
			case (rq.mode)
				MODE_SEND: begin
					need = HDR_BYTES + rq.msg_length;
					if (in_progress) begin
						res.status = ST_SEQUENCE;
					end else if (rq.msg_length == 0) begin
						res.status = ST_INVALID;
					end else if (need > capacity || capacity - fill < need) begin
						res.status = ST_FULL;
					end else begin
						put_byte(rq.msg_length[7:0]);
						put_byte(rq.msg_length[15:8]);
						put_byte(8'h00);
						put_byte(8'h00);
						send_left = rq.msg_length;
						res.length_out = rq.msg_length;
					end
				end
				MODE_PAYLOAD: begin
					if (send_left == 0) begin
						res.status = ST_SEQUENCE;
					end else begin
						put_byte(rq.data_in);
						send_left--;
						res.last_byte = (send_left == 0);
					end
				end
				MODE_RECV: begin
					if (in_progress) begin
						res.status = ST_SEQUENCE;
					end else if (fill == 0) begin
						res.status = ST_EMPTY;
					end else if (fill < HDR_BYTES) begin
						res.status = ST_INTERNAL;
					end else begin
						// gather the little-endian header without consuming it
						p = rd_pos;
						hdr_len = 0;
						for (int k = 0; k < HDR_BYTES; k++) begin
							hdr_len |= int'(byte_store[p]) << (8 * k);
							p = step_pos(p);
						end
						if (HDR_BYTES + hdr_len > fill) begin
							res.status = ST_INTERNAL;
						end else if (rq.reader_room < hdr_len) begin
							res.status = ST_FULL;
						end else begin
							repeat (HDR_BYTES) void'(take_byte());
							recv_left = hdr_len;
							res.length_out = hdr_len[15:0];
							res.last_byte = (hdr_len == 0);
						end
					end
				end
				MODE_READ: begin
					if (recv_left == 0) begin
						res.status = ST_SEQUENCE;
					end else begin
						res.data_out = take_byte();
						recv_left--;
						res.last_byte = (recv_left == 0);
					end
				end
				MODE_CLEAR: begin
					wipe();
				end
				default: begin
					res.status = ST_INVALID;
				end
			endcase
			res.used_bytes = CNT_W'(fill);
			res.free_bytes = CNT_W'(capacity - fill);
			pending_results.push_back(res);
		endfunction

		// Compare one strobed result with the oldest owed result
		function void check_result(ring_result_t got);
			ring_result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d", got.status);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.data_out !== want.data_out) begin
				$error("data_out: expected %0d, actual %0d", want.data_out, got.data_out);
				mismatches++;
			end
			if (got.length_out !== want.length_out) begin
				$error("length_out: expected %0d, actual %0d", want.length_out,
					got.length_out);
				mismatches++;
			end
			if (got.last_byte !== want.last_byte) begin
				$error("last_byte: expected %0d, actual %0d", want.last_byte, got.last_byte);
				mismatches++;
			end
			if (got.used_bytes !== want.used_bytes) begin
				$error("used_bytes: expected %0d, actual %0d", want.used_bytes,
					got.used_bytes);
				mismatches++;
			end
			if (got.free_bytes !== want.free_bytes) begin
				$error("free_bytes: expected %0d, actual %0d", want.free_bytes,
					got.free_bytes);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic [2:0]       mode        = MODE_CLEAR;
	logic [15:0]      msg_length  = '0;
	logic [7:0]       data_in     = '0;
	logic [15:0]      reader_room = '0;
	logic             cfg_valid   = 1'b0;
	logic [CNT_W-1:0] cfg_data    = '0;
	logic             busy;
	logic             cfg_ready;
	logic             done;
	logic [2:0]       status;
	logic [7:0]       data_out;
	logic [15:0]      length_out;
	logic             last_byte;
	logic [CNT_W-1:0] used_bytes;
	logic [CNT_W-1:0] free_bytes;

	msg_ring_scoreboard sb = new();
	int unsigned        quiet_cycles = 0;

	always #6 clk = ~clk;

	length_prefixed_message_ring dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.msg_length  (msg_length),
		.data_in     (data_in),
		.reader_room (reader_room),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.data_out    (data_out),
		.length_out  (length_out),
		.last_byte   (last_byte),
		.used_bytes  (used_bytes),
		.free_bytes  (free_bytes)
	);

	// Check every strobed result
	always @(posedge clk) begin : watch_results
		ring_result_t seen;
		if (arst_n && done === 1'b1) begin
			seen.status     = status;
			seen.data_out   = data_out;
			seen.length_out = length_out;
			seen.last_byte  = last_byte;
			seen.used_bytes = used_bytes;
			seen.free_bytes = free_bytes;
			sb.check_result(seen);
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Present one request and hold it until the block takes it
	task automatic issue(input logic [2:0] m, input logic [15:0] len,
			input logic [7:0] din, input logic [15:0] room);
		ring_request_t rq;
		rq.mode        = m;
		rq.msg_length  = len;
		rq.data_in     = din;
		rq.reader_room = room;
		start       <= 1'b1;
		mode        <= m;
		msg_length  <= len;
		data_in     <= din;
		reader_room <= room;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		sb.note_request(rq);
	endtask

	// Drop start for a short random burst
	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Write the capacity once the ring has gone quiet
	task automatic write_capacity(input logic [CNT_W-1:0] value);
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		sb.set_capacity(value);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed send and receive sequences, with some noise mixed in
	task automatic traffic(input int count, input int idle_pct);
		int          pick;
		int          shape;
		int unsigned free_now;
		logic [15:0] len;
		logic [15:0] room;
		for (int i = 0; i < count; i++) begin
			sender_gap(idle_pct);
			pick = $urandom_range(0, 99);
			free_now = sb.capacity - sb.fill;
			if (pick < 6) begin
				issue(3'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
			end else if (pick < 8) begin
				issue(MODE_CLEAR, 16'($urandom), 8'($urandom), 16'($urandom));
			end else if (sb.send_left != 0) begin
				if (pick < 12) begin
					issue($urandom_range(0, 1) ? MODE_SEND : MODE_READ, 16'($urandom_range(1, 8)),
						8'($urandom), 16'hFFFF);
				end else begin
					issue(MODE_PAYLOAD, 16'($urandom), 8'($urandom), 16'($urandom));
				end
			end else if (sb.recv_left != 0) begin
				if (pick < 12) begin
					issue($urandom_range(0, 1) ? MODE_RECV : MODE_PAYLOAD,
						16'($urandom_range(1, 8)), 8'($urandom), 16'hFFFF);
				end else begin
					issue(MODE_READ, 16'($urandom), 8'($urandom), 16'($urandom));
				end
			end else if (pick < ((sb.fill > sb.capacity / 2) ? 40 : 60)) begin
				// pick a payload length: mostly short, sometimes an exact fit or a reject
				shape = $urandom_range(0, 19);
				if (shape == 0) begin
					len = 16'h0000;
				end else if (shape == 1) begin
					len = 16'($urandom);
				end else if (shape <= 3 && free_now > HDR_BYTES && free_now - HDR_BYTES <= 64) begin
					len = 16'(free_now - HDR_BYTES);
				end else if (shape == 4 && sb.capacity <= 320 && $urandom_range(0, 3) == 0) begin
					len = 16'(sb.capacity - HDR_BYTES + $urandom_range(0, 1));
				end else begin
					len = 16'($urandom_range(1, 12));
				end
				issue(MODE_SEND, len, 8'($urandom), 16'($urandom));
			end else begin
				shape = $urandom_range(0, 9);
				if (shape == 0) begin
					room = 16'($urandom_range(0, 3));
				end else if (shape == 1) begin
					room = 16'($urandom);
				end else begin
					room = 16'hFFFF;
				end
				issue(MODE_RECV, 16'($urandom), 8'($urandom), room);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray bytes, empty ring, unknown modes, length rejects
		issue(MODE_READ, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_PAYLOAD, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_RECV, 16'h0000, 8'h00, 16'hFFFF);
		issue(MODE_UNUSED_FIRST, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_UNUSED_MID, 16'hFFFF, 8'hFF, 16'hFFFF);
		issue(MODE_UNUSED_LAST, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_SEND, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_SEND, 16'hFFFF, 8'h00, 16'h0000);
		issue(MODE_SEND, 16'(STORE_DEPTH - HDR_BYTES + 1), 8'h00, 16'h0000);
		// Directed: open a send, collide with begins, fill it, overrun it
		issue(MODE_SEND, 16'd3, 8'h00, 16'h0000);
		issue(MODE_SEND, 16'd2, 8'h00, 16'h0000);
		issue(MODE_RECV, 16'h0000, 8'h00, 16'hFFFF);
		issue(MODE_PAYLOAD, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_PAYLOAD, 16'h0000, 8'hFF, 16'h0000);
		issue(MODE_PAYLOAD, 16'h0000, 8'hA5, 16'h0000);
		issue(MODE_PAYLOAD, 16'h0000, 8'h11, 16'h0000);
		issue(MODE_SEND, 16'd1, 8'h00, 16'h0000);
		issue(MODE_PAYLOAD, 16'h0000, 8'h5A, 16'h0000);
		// Directed: short reader room, then drain the first message
		issue(MODE_RECV, 16'h0000, 8'h00, 16'd2);
		issue(MODE_RECV, 16'h0000, 8'h00, 16'd3);
		issue(MODE_READ, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_READ, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_READ, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_RECV, 16'h0000, 8'h00, 16'h0000);
		issue(MODE_CLEAR, 16'h0000, 8'h00, 16'h0000);

		// Random traffic across capacities, extremes included
		traffic(150, 30);
		write_capacity('0);
		traffic(200, 30);
		write_capacity(CNT_W'(6));
		traffic(150, 0);
		write_capacity('1);
		traffic(150, 50);
		write_capacity(CNT_W'(37));
		traffic(250, 30);
		write_capacity(CNT_W'(HDR_BYTES));
		traffic(150, 30);
		write_capacity(CNT_W'(300));
		traffic(250, 30);
		write_capacity(CNT_W'($urandom_range(CAP_MIN, 200)));
		traffic(250, 30);
		write_capacity(CNT_W'(STORE_DEPTH));
		traffic(100, 30);
		write_capacity(CNT_W'(13));
		traffic(300, 0);

		// Drain outstanding results and settle
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
